FILE: rtl/core/urs_pkg.sv
// ----------------------------------------------------------------------------
// urs_pkg
// Shared types and constants of the ultrasonic ranging scanner.
// ----------------------------------------------------------------------------
package urs_pkg;

    localparam int SENSORS    = 4;
    localparam int SLOT_W     = 2;
    localparam int ECHO_W     = 16;
    localparam int OFS_W      = 11;
    localparam int DIST_W     = 12;
    localparam int SAFE_W     = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int OUTL_W     = 2;

    localparam logic [ECHO_W-1:0] MAX_TIME     = 16'd40600;
    localparam logic [ECHO_W-1:0] MIN_TIME     = 16'd250;
    localparam logic [OUTL_W-1:0] MAX_OUTLIERS = 2'd2;

    // time/58 = (time/2)/29, reciprocal of 29 scaled by 2^20
    localparam logic [15:0] DIV29_MUL = 16'd36158;
    localparam int          DIV_SHIFT = 20;

    typedef enum logic [1:0] {
        FUNC_TIMER = 2'd0,
        FUNC_ECHO  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_RUN   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_GAP   = 2'd1,
        CMD_PULSE = 2'd2,
        CMD_STOP  = 2'd3
    } t_timer_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE   = 3'd0,
        REG_OFFSET_0 = 3'd1,
        REG_OFFSET_1 = 3'd2,
        REG_OFFSET_2 = 3'd3,
        REG_OFFSET_3 = 3'd4,
        REG_SAFETY   = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]        func;
        logic [ECHO_W-1:0] echo_time;
        logic [SLOT_W-1:0] sensor;
        logic              run_on;
    } t_in_item;

    typedef struct packed {
        logic [SENSORS-1:0]       trigger_pins;
        logic [1:0]               timer_cmd;
        logic                     capture_on;
        logic signed [DIST_W-1:0] distance;
        logic                     was_ready;
        logic                     too_close;
        logic [SLOT_W-1:0]        active_sensor;
    } t_out_item;

    typedef struct packed {
        logic signed [DIST_W-1:0] distance;
        logic                     too_close;
    } t_range_res;

endpackage

FILE: rtl/core/urs_range_calc.sv
// ----------------------------------------------------------------------------
// urs_range_calc
// Converts a stored echo time to a saturated centimetre distance and
// compares it against the safety distance.
// ----------------------------------------------------------------------------
module urs_range_calc
    import urs_pkg::*;
(
    input  logic [ECHO_W-1:0]       i_echo,
    input  logic signed [OFS_W-1:0] i_offset,
    input  logic [SAFE_W-1:0]       i_safety,
    output t_range_res              o_res
);

    logic [ECHO_W-2:0]        w_half;
    logic [30:0]              w_prod;
    logic [10:0]              w_quot;
    logic signed [12:0]       w_sum;
    logic signed [DIST_W-1:0] w_dist;

    assign w_half = i_echo[ECHO_W-1:1];
    assign w_prod = 31'(w_half) * 31'(DIV29_MUL);
    assign w_quot = w_prod[DIV_SHIFT+10:DIV_SHIFT];
    assign w_sum  = $signed({2'b00, w_quot}) + $signed({{2{i_offset[OFS_W-1]}}, i_offset});

    always_comb begin
        priority if (w_sum > 13'sd2047) begin
            w_dist = 12'sd2047;
        end else if (w_sum < -13'sd2048) begin
            w_dist = -12'sd2048;
        end else begin
            w_dist = w_sum[DIST_W-1:0];
        end
    end

    assign o_res.distance  = w_dist;
    assign o_res.too_close = $signed({{3{w_dist[DIST_W-1]}}, w_dist})
                             < $signed({1'b0, i_safety});

endmodule

FILE: rtl/core/ultrasonic_ranging_scanner_top.sv
// ----------------------------------------------------------------------------
// ultrasonic_ranging_scanner_top
// Round-robin trigger sequencing, echo filtering and distance reads for
// four ultrasonic sensors.
// ----------------------------------------------------------------------------
// an accepted transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle while results are taken, set by the input and result registers
// each event is decided in one pass between them and updates state at once
// reset clears all state and configuration; the scan slot starts at sensor 3
module ultrasonic_ranging_scanner_top
    import urs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    // configuration
    logic [SENSORS-1:0]       r_enable;
    logic signed [OFS_W-1:0]  r_offset [SENSORS];
    logic [SAFE_W-1:0]        r_safety;

    // scan state
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic                     r_pulse, n_pulse;
    logic                     r_running, n_running;
    logic                     r_capture, n_capture;
    logic [ECHO_W-1:0]        r_echo [SENSORS];
    logic [ECHO_W-1:0]        n_echo [SENSORS];
    logic [OUTL_W-1:0]        r_outl [SENSORS];
    logic [OUTL_W-1:0]        n_outl [SENSORS];
    logic [SENSORS-1:0]       r_ready, n_ready;

    // pipeline
    logic                     r_in_valid;
    t_in_item                 r_in;
    logic                     r_out_valid;
    t_out_item                r_out, n_out;

    logic                     w_adv;
    logic                     w_proc;
    logic [SLOT_W-1:0]        w_next_slot;
    logic [OUTL_W-1:0]        w_outl_inc;
    logic                     w_outlier;
    t_timer_cmd               w_cmd;
    logic                     w_was;
    t_range_res               w_range;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_proc     = r_in_valid && w_adv;
    assign o_in_ready = !r_in_valid || w_adv;

    assign w_next_slot = (r_slot == SLOT_W'(SENSORS-1)) ? '0 : r_slot + 1'b1;
    assign w_outl_inc  = r_outl[r_slot] + 1'b1;
    assign w_outlier   = (r_in.echo_time > MAX_TIME) || (r_in.echo_time < MIN_TIME);

    urs_range_calc u_range_calc (
        .i_echo   (r_echo[r_in.sensor]),
        .i_offset (r_offset[r_in.sensor]),
        .i_safety (r_safety),
        .o_res    (w_range)
    );

    always_comb begin
        n_slot    = r_slot;
        n_pulse   = r_pulse;
        n_running = r_running;
        n_capture = r_capture;
        n_echo    = r_echo;
        n_outl    = r_outl;
        n_ready   = r_ready;
        w_cmd     = CMD_NONE;
        w_was     = 1'b0;
        unique case (t_func'(r_in.func))
            FUNC_TIMER: begin
                if (r_pulse) begin
                    n_pulse = 1'b0;
                    w_cmd   = CMD_STOP;
                end else begin
                    n_slot = w_next_slot;
                    if (r_running) begin
                        n_pulse = r_enable[w_next_slot];
                        w_cmd   = CMD_PULSE;
                    end else begin
                        w_cmd     = CMD_STOP;
                        n_capture = 1'b0;
                    end
                end
            end
            FUNC_ECHO: begin
                if (r_capture) begin
                    if (w_outlier) begin
                        n_outl[r_slot] = w_outl_inc;
                        // too many outliers in a row: take the maximum time
                        if (w_outl_inc > MAX_OUTLIERS) begin
                            n_echo[r_slot]  = MAX_TIME;
                            n_outl[r_slot]  = '0;
                            n_ready[r_slot] = 1'b1;
                        end
                    end else begin
                        n_echo[r_slot]  = r_in.echo_time;
                        n_outl[r_slot]  = '0;
                        n_ready[r_slot] = 1'b1;
                    end
                    w_cmd = CMD_GAP;
                end
            end
            FUNC_READ: begin
                w_was               = r_ready[r_in.sensor];
                n_ready[r_in.sensor] = 1'b0;
            end
            FUNC_RUN: begin
                if (r_in.run_on && !r_running) begin
                    w_cmd     = CMD_GAP;
                    n_capture = 1'b1;
                end
                n_running = r_in.run_on;
            end
        endcase
    end

    always_comb begin
        n_out               = '0;
        n_out.trigger_pins  = n_pulse ? (SENSORS'(1) << n_slot) : '0;
        n_out.timer_cmd     = w_cmd;
        n_out.capture_on    = n_capture;
        n_out.was_ready     = w_was;
        n_out.active_sensor = n_slot;
        if (t_func'(r_in.func) == FUNC_READ) begin
            n_out.distance  = w_range.distance;
            n_out.too_close = w_range.too_close;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_safety <= '0;
            for (int i = 0; i < SENSORS; i++) begin
                r_offset[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:   r_enable    <= i_cfg_data[SENSORS-1:0];
                REG_OFFSET_0: r_offset[0] <= i_cfg_data[OFS_W-1:0];
                REG_OFFSET_1: r_offset[1] <= i_cfg_data[OFS_W-1:0];
                REG_OFFSET_2: r_offset[2] <= i_cfg_data[OFS_W-1:0];
                REG_OFFSET_3: r_offset[3] <= i_cfg_data[OFS_W-1:0];
                REG_SAFETY:   r_safety    <= i_cfg_data[SAFE_W-1:0];
                default: begin
                    // unused register index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= SLOT_W'(SENSORS-1);
            r_pulse   <= 1'b0;
            r_running <= 1'b0;
            r_capture <= 1'b0;
            r_ready   <= '0;
            for (int i = 0; i < SENSORS; i++) begin
                r_echo[i] <= '0;
                r_outl[i] <= '0;
            end
        end else if (w_proc) begin
            r_slot    <= n_slot;
            r_pulse   <= n_pulse;
            r_running <= n_running;
            r_capture <= n_capture;
            r_ready   <= n_ready;
            r_echo    <= n_echo;
            r_outl    <= n_outl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a trigger pulse only runs while the capture unit is enabled
    a_pulse_needs_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse |-> r_capture)
        else $error("trigger pulse active with capture disabled");

    // at most one trigger line, and it belongs to the reported slot
    a_trigger_matches_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.trigger_pins != '0)) |->
        ($onehot(r_out.trigger_pins)
         && (r_out.trigger_pins == (SENSORS'(1) << r_out.active_sensor))))
        else $error("trigger lines disagree with active sensor");

    // a stalled result keeps its transaction
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("result changed while stalled");

    // state only moves when a transaction is processed
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_proc |=> ($stable(r_slot) && $stable(r_pulse) && $stable(r_ready)))
        else $error("scan state changed without a transaction");

    // distance is only reported for a read
    a_distance_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (t_func'(r_in.func) != FUNC_READ)) |=>
        ((r_out.distance == '0) && !r_out.was_ready && !r_out.too_close))
        else $error("read fields set on a non-read transaction");

endmodule

FILE: sim/tb_ultrasonic_ranging_scanner_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_ranging_scanner_top
// Self-checking bench for the four-sensor ultrasonic ranging scanner. A short
// table of directed events covers reset values, echo outliers, pulse and gap
// expiries and signed reads, followed by randomized event streams under
// several register settings. Every result is checked field by field against
// the in-bench scan model or typed row, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_ultrasonic_ranging_scanner_top;
    import urs_pkg::*;

    localparam int                   US_PER_CM     = 58;
    localparam int                   IDLE_LIMIT    = 2000;
    localparam int                   PHASES        = 6;
    localparam int                   PHASE_ITEMS   = 250;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd6;

    typedef struct {
        t_in_item  stim;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in       = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out;

    // scanner model state and register copies
    logic [SLOT_W-1:0]        slot_q;
    bit                       pulse_on;
    bit                       scan_on;
    bit                       capture_en;
    logic [ECHO_W-1:0]        echo_mem [SENSORS];
    logic [OUTL_W-1:0]        outlier_run [SENSORS];
    bit                       fresh [SENSORS];
    logic [SENSORS-1:0]       en_mask;
    logic signed [OFS_W-1:0]  ofs_cm [SENSORS];
    logic [SAFE_W-1:0]        safe_cm;

    t_out_item expected_reports [$];
    t_dir_row  dir_rows [$];
    int        report_errors = 0;
    int        idle_cycles   = 0;
    int        rx_wait       = 0;
    bit        tx_quiet      = 1'b0;
    bit        rx_quiet      = 1'b0;

    ultrasonic_ranging_scanner_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item scan_step(t_in_item it);
        t_out_item r;
        int        dist_cm;
        int        s;
        r       = '0;
        dist_cm = 0;
        case (it.func)
            FUNC_TIMER: begin
                if (pulse_on) begin
                    pulse_on    = 1'b0;
                    r.timer_cmd = CMD_STOP;
                end else begin
                    slot_q = (slot_q == SENSORS - 1) ? '0 : slot_q + 1'b1;
                    if (scan_on) begin
                        if (en_mask[slot_q])
                            pulse_on = 1'b1;
                        r.timer_cmd = CMD_PULSE;
                    end else begin
                        r.timer_cmd = CMD_STOP;
                        capture_en  = 1'b0;
                    end
                end
            end
            FUNC_ECHO: begin
                if (capture_en) begin
                    s = slot_q;
                    if (it.echo_time > MAX_TIME || it.echo_time < MIN_TIME) begin
                        outlier_run[s] = outlier_run[s] + 1'b1;
                        if (outlier_run[s] > MAX_OUTLIERS) begin
                            // too many outliers in a row: take the maximum range
                            echo_mem[s]    = MAX_TIME;
                            outlier_run[s] = '0;
                            fresh[s]       = 1'b1;
                        end
                    end else begin
                        echo_mem[s]    = it.echo_time;
                        outlier_run[s] = '0;
                        fresh[s]       = 1'b1;
                    end
                    r.timer_cmd = CMD_GAP;
                end
            end
            FUNC_READ: begin
                s       = it.sensor;
                dist_cm = int'(echo_mem[s]) / US_PER_CM + int'(ofs_cm[s]);
                if (dist_cm > 2047)
                    dist_cm = 2047;
                if (dist_cm < -2048)
                    dist_cm = -2048;
                r.was_ready = fresh[s];
                fresh[s]    = 1'b0;
                r.too_close = (dist_cm < int'(safe_cm));
            end
            default: begin
                if (it.run_on && !scan_on) begin
                    r.timer_cmd = CMD_GAP;
                    capture_en  = 1'b1;
                end
                scan_on = it.run_on;
            end
        endcase
        r.trigger_pins  = pulse_on ? (SENSORS'(1) << slot_q) : '0;
        r.capture_on    = capture_en;
        r.distance      = dist_cm[DIST_W-1:0];
        r.active_sensor = slot_q;
        return r;
    endfunction

    function automatic t_in_item ev(t_func f, logic [ECHO_W-1:0] e, logic [SLOT_W-1:0] s,
                                    logic run);
        t_in_item it;
        it.func      = f;
        it.echo_time = e;
        it.sensor    = s;
        it.run_on    = run;
        return it;
    endfunction

    function automatic t_out_item rep(logic [SENSORS-1:0] trig, t_timer_cmd cmd, logic cap,
                                      int dist_cm, logic was, logic close,
                                      logic [SLOT_W-1:0] act);
        t_out_item r;
        r.trigger_pins  = trig;
        r.timer_cmd     = cmd;
        r.capture_on    = cap;
        r.distance      = dist_cm[DIST_W-1:0];
        r.was_ready     = was;
        r.too_close     = close;
        r.active_sensor = act;
        return r;
    endfunction

    function automatic t_in_item random_event();
        t_in_item it;
        int       pick;
        it.echo_time = ECHO_W'($urandom);
        it.sensor    = SLOT_W'($urandom);
        it.run_on    = 1'($urandom);
        pick         = $urandom_range(0, 99);
        if (pick < 40) begin
            it.func = FUNC_TIMER;
        end else if (pick < 75) begin
            it.func = FUNC_ECHO;
            case ($urandom_range(0, 9))
                7:       it.echo_time = ECHO_W'($urandom_range(0, MIN_TIME - 1));
                8:       it.echo_time = ECHO_W'($urandom_range(MAX_TIME + 1, 65535));
                9:       it.echo_time = ECHO_W'($urandom);
                default: it.echo_time = ECHO_W'($urandom_range(MIN_TIME, MAX_TIME));
            endcase
        end else if (pick < 92) begin
            it.func = FUNC_READ;
        end else begin
            it.func   = FUNC_RUN;
            it.run_on = ($urandom_range(0, 9) != 0);
        end
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [SENSORS-1:0] mask, int o0, int o1, int o2, int o3,
                                int safe);
        int ofs_v [SENSORS];
        ofs_v = '{o0, o1, o2, o3};
        write_reg(REG_ENABLE, CFG_DATA_W'(mask));
        en_mask = mask;
        for (int k = 0; k < SENSORS; k++) begin
            write_reg(CFG_IDX_W'(REG_OFFSET_0 + k), CFG_DATA_W'(ofs_v[k]));
            ofs_cm[k] = OFS_W'(ofs_v[k]);
        end
        write_reg(REG_SAFETY, CFG_DATA_W'(safe));
        safe_cm = SAFE_W'(safe);
        // index past the register file must be ignored
        write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_event(t_in_item it, bit typed, t_out_item want);
        int        gap;
        t_out_item model;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        model = scan_step(it);
        expected_reports.push_back(typed ? want : model);
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // result side: check each transaction, then draw a stall
    always @(posedge i_clk) begin
        t_out_item want;
        int        n;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait     <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                report_errors++;
                if (report_errors <= 10)
                    $display("unexpected result transaction: %h", o_out);
            end else begin
                want = expected_reports.pop_front();
                if (want.trigger_pins !== o_out.trigger_pins ||
                    want.timer_cmd !== o_out.timer_cmd ||
                    want.capture_on !== o_out.capture_on ||
                    want.distance !== o_out.distance ||
                    want.was_ready !== o_out.was_ready ||
                    want.too_close !== o_out.too_close ||
                    want.active_sensor !== o_out.active_sensor) begin
                    report_errors++;
                    if (report_errors <= 10) begin
                        $display("mismatch: exp trig=%h cmd=%0d cap=%0d dist=%0d was=%0d close=%0d slot=%0d",
                                 want.trigger_pins, want.timer_cmd, want.capture_on,
                                 $signed(want.distance), want.was_ready, want.too_close,
                                 want.active_sensor);
                        $display("          got trig=%h cmd=%0d cap=%0d dist=%0d was=%0d close=%0d slot=%0d",
                                 o_out.trigger_pins, o_out.timer_cmd,
                                 o_out.capture_on, $signed(o_out.distance), o_out.was_ready,
                                 o_out.too_close, o_out.active_sensor);
                    end
                end
            end
            n = rx_quiet ? 0 : $urandom_range(0, 14);
            rx_wait     <= n;
            i_out_ready <= (n == 0);
        end else if (rx_wait > 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_ready <= (rx_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ultrasonic_ranging_scanner_top test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        slot_q     = SENSORS - 1;
        pulse_on   = 1'b0;
        scan_on    = 1'b0;
        capture_en = 1'b0;
        en_mask    = '0;
        safe_cm    = '0;
        for (int k = 0; k < SENSORS; k++) begin
            echo_mem[k]    = '0;
            outlier_run[k] = '0;
            fresh[k]       = 1'b0;
            ofs_cm[k]      = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sensors 0 and 2 enabled, offsets at both extremes, widest safety distance
        apply_config(4'b0101, -1000, 1000, 0, 5, 10000);
        dir_rows.push_back('{ev(FUNC_READ, 0, 0, 0), 1'b1,
                             rep(4'b0000, CMD_NONE, 1'b0, -1000, 1'b0, 1'b1, 2'd3)});
        dir_rows.push_back('{ev(FUNC_ECHO, 1234, 0, 0), 1'b1,
                             rep(4'b0000, CMD_NONE, 1'b0, 0, 1'b0, 1'b0, 2'd3)});
        dir_rows.push_back('{ev(FUNC_TIMER, 0, 0, 0), 1'b1,
                             rep(4'b0000, CMD_STOP, 1'b0, 0, 1'b0, 1'b0, 2'd0)});
        dir_rows.push_back('{ev(FUNC_RUN, 0, 0, 1), 1'b1,
                             rep(4'b0000, CMD_GAP, 1'b1, 0, 1'b0, 1'b0, 2'd0)});
        dir_rows.push_back('{ev(FUNC_RUN, 0, 0, 1), 1'b1,
                             rep(4'b0000, CMD_NONE, 1'b1, 0, 1'b0, 1'b0, 2'd0)});
        // disabled sensor gets its slot but no pulse
        dir_rows.push_back('{ev(FUNC_TIMER, 16'hffff, 3, 1), 1'b0, '0});
        // three outliers in a row force the maximum time
        dir_rows.push_back('{ev(FUNC_ECHO, 16'hffff, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_ECHO, MIN_TIME - 1, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_ECHO, MAX_TIME + 1, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_READ, 0, 1, 0), 1'b1,
                             rep(4'b0000, CMD_NONE, 1'b1, 1700, 1'b1, 1'b1, 2'd1)});
        dir_rows.push_back('{ev(FUNC_READ, 0, 1, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_TIMER, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_TIMER, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_ECHO, MIN_TIME, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_ECHO, MAX_TIME, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_READ, 0, 2, 0), 1'b0, '0});
        // scan off takes effect only at the next gap expiry
        dir_rows.push_back('{ev(FUNC_RUN, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_ECHO, 1000, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_TIMER, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_READ, 0, 3, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_RUN, 0, 0, 0), 1'b0, '0});
        dir_rows.push_back('{ev(FUNC_READ, 0, 0, 0), 1'b0, '0});
        foreach (dir_rows[k])
            send_event(dir_rows[k].stim, dir_rows[k].typed, dir_rows[k].want);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0:       apply_config(4'b0000, -1000, -1000, -1000, -1000, 0);
                1:       apply_config(4'b1111, 1000, 1000, 1000, 1000, 10000);
                default: apply_config(SENSORS'($urandom), $urandom_range(0, 2000) - 1000,
                                      $urandom_range(0, 2000) - 1000,
                                      $urandom_range(0, 2000) - 1000,
                                      $urandom_range(0, 2000) - 1000,
                                      $urandom_range(0, 10000));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                send_event(random_event(), 1'b0, '0);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (report_errors == 0)
            $display("ultrasonic_ranging_scanner_top test passed");
        else
            $display("ultrasonic_ranging_scanner_top test failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/urs_pkg.sv
rtl/core/urs_range_calc.sv
rtl/core/ultrasonic_ranging_scanner_top.sv
sim/tb_ultrasonic_ranging_scanner_top.sv
